// ===== hw/rtl/irpd_pkg.sv =====
// Shared types and constants for the infrared pulse-width packet decoder.
// Holds the configuration record, the event record, the decode modes and the width constants.
// Depends on nothing.
package irpd_pkg;

    localparam int unsigned PACKET_BITS_DEFAULT = 32;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned TOL_W       = 14;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned WIN_W       = 18;

    localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;
    localparam logic [COUNT_W-1:0] START_TICKS_RESET   = 16'd90;
    localparam logic [COUNT_W-1:0] ZERO_TICKS_RESET    = 16'd20;
    localparam logic [COUNT_W-1:0] ONE_TICKS_RESET     = 16'd40;
    localparam logic [TOL_W-1:0]   TOLERANCE_TICKS_RESET = 14'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START     = 2'd0,
        CFG_ZERO      = 2'd1,
        CFG_ONE       = 2'd2,
        CFG_TOLERANCE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_WAITING = 2'd0,
        MODE_READING = 2'd1,
        MODE_ERROR   = 2'd2
    } mode_t;

    typedef enum logic {
        EV_EDGE    = 1'b0,
        EV_TIMEOUT = 1'b1
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t kind;
        logic     is_start;
        logic     is_zero;
        logic     is_one;
    } event_t;

    typedef struct packed {
        logic [COUNT_W-1:0] start_ticks;
        logic [COUNT_W-1:0] zero_ticks;
        logic [COUNT_W-1:0] one_ticks;
        logic [TOL_W-1:0]   tolerance_ticks;
    } cfg_t;

endpackage

// ===== hw/rtl/irpd_front.sv =====
// Front end: takes one tick per request, counts ticks between pin changes and classifies intervals.
// Pushes edge and timeout events into the event queue.
// Depends on irpd_pkg.
module irpd_front
    import irpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   pin_level,
    input  logic   receive_enabled,
    input  logic   queue_full,
    output logic   push,
    output event_t push_event
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               prev_level_reg;
    logic               prev_level_next;

    logic                     accept;
    logic [COUNT_W-1:0]       count_inc;
    logic signed [WIN_W-1:0]  t;
    logic signed [WIN_W-1:0]  st;
    logic signed [WIN_W-1:0]  zt;
    logic signed [WIN_W-1:0]  ot;
    logic signed [WIN_W-1:0]  tol;
    logic signed [WIN_W-1:0]  tol4;
    logic [WIN_W-1:0]         timeout_limit;
    logic                     in_start;
    logic                     in_zero;
    logic                     in_one;

    assign in_stall = queue_full;

    always_comb
    begin
        accept    = in_valid && !in_stall;
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        t    = signed'({2'b00, count_reg});
        st   = signed'({2'b00, cfg.start_ticks});
        zt   = signed'({2'b00, cfg.zero_ticks});
        ot   = signed'({2'b00, cfg.one_ticks});
        tol  = signed'({4'b0000, cfg.tolerance_ticks});
        tol4 = signed'({2'b00, cfg.tolerance_ticks, 2'b00});

        in_start = (t > st - tol4) && (t < st + tol);
        in_zero  = (t > zt - tol) && (t < zt + tol);
        in_one   = (t > ot - tol) && (t < ot + tol);

        timeout_limit = {2'b00, cfg.start_ticks} + {1'b0, cfg.start_ticks, 1'b0};

        count_next          = count_reg;
        prev_level_next     = prev_level_reg;
        push                = 1'b0;
        push_event.kind     = EV_EDGE;
        push_event.is_start = in_start;
        push_event.is_zero  = in_zero;
        push_event.is_one   = in_one;

        if (accept)
        begin
            if (pin_level != prev_level_reg)
            begin
                count_next      = '0;
                prev_level_next = pin_level;
                push            = pin_level && receive_enabled;
            end
            else
            begin
                count_next = count_inc;
                if ({2'b00, count_inc} > timeout_limit)
                begin
                    push            = 1'b1;
                    push_event.kind = EV_TIMEOUT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_level_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            prev_level_reg <= prev_level_next;
        end
    end

endmodule

// ===== hw/rtl/irpd_queue.sv =====
// Short event queue between the front end and the packet assembler.
// A small circular buffer with a fill count.
// Depends on irpd_pkg.
module irpd_queue
    import irpd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_event,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output event_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    event_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        head_valid = (count_reg != '0);
        head       = entries[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;

        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/irpd_back.sv =====
// Packet assembler: runs the decode mode machine on queued events and shifts in bits.
// Holds the completed packet in an output register until it is taken.
// Depends on irpd_pkg.
module irpd_back
    import irpd_pkg::*;
#(
    parameter int unsigned PACKET_BITS = PACKET_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  event_t            head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] packet_data
);

    localparam int unsigned BITS_W = $clog2(PACKET_BITS + 1);

    mode_t              mode_reg;
    mode_t              mode_next;
    mode_t              mode_upd;
    logic [BITS_W-1:0]  bits_reg;
    logic [BITS_W-1:0]  bits_next;
    logic [BITS_W-1:0]  bits_upd;
    logic [BITS_W-1:0]  bits_inc;
    logic [DATA_W-1:0]  buf_reg;
    logic [DATA_W-1:0]  buf_next;
    logic [DATA_W-1:0]  buf_upd;
    logic [DATA_W-1:0]  shifted;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  data_next;
    logic               emit;
    logic               slot_free;

    assign out_valid   = out_valid_reg;
    assign packet_data = data_reg;

    always_comb
    begin
        slot_free = !out_valid_reg || !out_stall;
        shifted   = {buf_reg[DATA_W-2:0], head.is_one && !head.is_zero};
        bits_inc  = bits_reg + 1'b1;

        mode_upd = mode_reg;
        bits_upd = bits_reg;
        buf_upd  = buf_reg;
        emit     = 1'b0;

        if (head_valid)
        begin
            unique case (head.kind)
                EV_TIMEOUT:
                begin
                    if (mode_reg == MODE_READING)
                    begin
                        mode_upd = MODE_WAITING;
                    end
                end
                EV_EDGE:
                begin
                    priority if (head.is_start)
                    begin
                        mode_upd = MODE_READING;
                        bits_upd = '0;
                        buf_upd  = '0;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_WAITING:
                            begin
                                mode_upd = MODE_WAITING;
                            end
                            MODE_READING:
                            begin
                                if (head.is_zero || head.is_one)
                                begin
                                    buf_upd = shifted;
                                    if (bits_inc == BITS_W'(PACKET_BITS))
                                    begin
                                        emit     = 1'b1;
                                        bits_upd = '0;
                                        mode_upd = MODE_WAITING;
                                    end
                                    else
                                    begin
                                        bits_upd = bits_inc;
                                    end
                                end
                                else
                                begin
                                    mode_upd = MODE_ERROR;
                                end
                            end
                            default:
                            begin
                                mode_upd = MODE_WAITING;
                            end
                        endcase
                    end
                end
                default:
                begin
                    mode_upd = mode_reg;
                end
            endcase
        end

        pop = head_valid && !(emit && !slot_free);

        mode_next = pop ? mode_upd : mode_reg;
        bits_next = pop ? bits_upd : bits_reg;
        buf_next  = pop ? buf_upd : buf_reg;

        data_next      = data_reg;
        out_valid_next = out_valid_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            data_next      = shifted;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAITING;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        data_reg <= data_next;
    end

`ifndef SYNTHESIS
    bits_in_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg < BITS_W'(PACKET_BITS))
        else $error("Bit count reached the packet length without completing a packet.");

    packet_from_reading_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(mode_reg) == MODE_READING)
        else $error("A packet was delivered while the decoder was not reading.");

    start_enters_reading_a: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == EV_EDGE && head.is_start) |=> mode_reg == MODE_READING)
        else $error("A start interval did not put the decoder into reading mode.");

    held_packet_kept_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(data_reg)))
        else $error("A waiting packet was lost or overwritten.");
`endif

endmodule

// ===== hw/rtl/ir_pulse_width_packet_decoder.sv =====
// Top level of the infrared pulse-width packet decoder: configuration registers and the
// front end, event queue and packet assembler. Depends on irpd_pkg, irpd_front, irpd_queue
// and irpd_back.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid / in_stall        pin_level, receive_enabled
//  out      output     out_valid / out_stall      packet_data
//  cfg      input      cfg_wr_en                  cfg_index, cfg_data
//
// One tick request is taken every cycle unless in_stall is high; a packet's last event is
// registered in a four-entry event queue, and the packet then in the assembler's output register.
// Reset clears the counter, mode and queue and loads the default interval settings.
// in_stall rises only when the event queue is full, which happens while out_stall holds a packet.
module ir_pulse_width_packet_decoder
    import irpd_pkg::*;
#(
    parameter int unsigned PACKET_BITS = PACKET_BITS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   pin_level,
    input  logic                   receive_enabled,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DATA_W-1:0]      packet_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   queue_full;
    logic   push;
    event_t push_event;
    logic   pop;
    logic   head_valid;
    event_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START:     cfg_next.start_ticks     = cfg_data;
                CFG_ZERO:      cfg_next.zero_ticks      = cfg_data;
                CFG_ONE:       cfg_next.one_ticks       = cfg_data;
                CFG_TOLERANCE: cfg_next.tolerance_ticks = cfg_data[TOL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ticks     <= START_TICKS_RESET;
            cfg_reg.zero_ticks      <= ZERO_TICKS_RESET;
            cfg_reg.one_ticks       <= ONE_TICKS_RESET;
            cfg_reg.tolerance_ticks <= TOLERANCE_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irpd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pin_level       (pin_level),
        .receive_enabled (receive_enabled),
        .queue_full      (queue_full),
        .push            (push),
        .push_event      (push_event)
    );

    irpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    irpd_back #(
        .PACKET_BITS (PACKET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_data (packet_data)
    );

endmodule
